### rtl/slb_pkg.sv
// shared types and constants of the slope limiter bank
`timescale 1ns / 1ps
package slb_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned MagW   = 32;
  localparam int unsigned ProdW  = 64;
  localparam int unsigned SumW   = 33;
  localparam int unsigned NumW   = 96;
  localparam int unsigned DenW   = 66;
  localparam int unsigned QuoW   = 33;
  localparam int unsigned ResW   = 34;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned KindW  = 3;

  localparam logic [AddrW-3:0] RegKind = 1'b0;

  typedef enum logic [KindW-1:0] {
    KIND_MINMOD  = 3'd0,
    KIND_MAXMOD  = 3'd1,
    KIND_MC      = 3'd2,
    KIND_SUPERBEE = 3'd3,
    KIND_VANLEER = 3'd4,
    KIND_OSPRE   = 3'd5,
    KIND_ALBADA  = 3'd6
  } kind_e;

  typedef struct packed {
    logic            neg;
    logic            direct;
    logic [ResW-1:0] dmag;
  } side_t;

endpackage

### rtl/slope_limiter_bank_unit.sv
// slope limiter bank top level: magnitudes, products, divider, rounding and saturation
`timescale 1ns / 1ps
// items pass stages 1 to 3, the one-bit-per-stage divider and the output register
// throughput: one item per cycle unless stalled, set by the fully pipelined divider
// a stall at the output freezes every stage together, nothing is dropped
// reset clears all valid bits and sets the limiter kind to van albada
// no clearing pass after reset, the block is ready at once
module slope_limiter_bank_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [slb_pkg::AddrW-1:0]       paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic signed [slb_pkg::WordW-1:0] left_slope_i,
  input  logic signed [slb_pkg::WordW-1:0] right_slope_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [slb_pkg::WordW-1:0] limited_slope_o,
  output logic                            saturated_o
);
  import slb_pkg::*;

  logic en;
  kind_e kind_q;

  // config port
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_ALBADA;
    end else if (psel && penable && pwrite && (paddr[AddrW-1:2] == RegKind)) begin
      kind_q <= kind_e'(pwdata[KindW-1:0]);
    end
  end
  assign prdata = (paddr[AddrW-1:2] == RegKind) ? 32'(kind_q) : '0;

  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: magnitudes and signs
  logic            v1_q, neg1_q, same1_q;
  logic [MagW-1:0] a1_q, b1_q;
  kind_e           kind1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a1_q    <= left_slope_i[WordW-1] ? MagW'(-left_slope_i) : MagW'(left_slope_i);
      b1_q    <= right_slope_i[WordW-1] ? MagW'(-right_slope_i) : MagW'(right_slope_i);
      neg1_q  <= left_slope_i[WordW-1];
      same1_q <= (left_slope_i != '0) && (right_slope_i != '0)
                 && (left_slope_i[WordW-1] == right_slope_i[WordW-1]);
      kind1_q <= kind_q;
    end
  end

  // stage 2: products, sum and the comparison limiters
  logic [ResW-1:0] mn, mx, sum_e, a2x, b2x, sb1, sb2, dmag_d;
  logic            direct_d;

  always_comb begin
    mn    = ResW'((a1_q < b1_q) ? a1_q : b1_q);
    mx    = ResW'((a1_q < b1_q) ? b1_q : a1_q);
    sum_e = ResW'(a1_q) + ResW'(b1_q);
    a2x   = ResW'(a1_q) << 1;
    b2x   = ResW'(b1_q) << 1;
    sb1   = (ResW'(b1_q) < a2x) ? ResW'(b1_q) : a2x;
    sb2   = (b2x < ResW'(a1_q)) ? b2x : ResW'(a1_q);
    direct_d = 1'b0;
    dmag_d   = '0;
    case (kind1_q)
      KIND_MINMOD: begin
        direct_d = 1'b1;
        dmag_d   = mn;
      end
      KIND_MAXMOD: begin
        direct_d = 1'b1;
        dmag_d   = mx;
      end
      KIND_MC: begin
        direct_d = 1'b1;
        dmag_d   = (sum_e < (mn << 2)) ? ((sum_e + ResW'(1)) >> 1) : (mn << 1);
      end
      KIND_SUPERBEE: begin
        direct_d = 1'b1;
        dmag_d   = (sb1 > sb2) ? sb1 : sb2;
      end
      default: begin
        direct_d = 1'b0;
        dmag_d   = '0;
      end
    endcase
    if (!same1_q) begin
      direct_d = 1'b1;
      dmag_d   = '0;
    end
  end

  logic             v2_q;
  logic [ProdW-1:0] ab2_q, aa2_q, bb2_q;
  logic [SumW-1:0]  sum2_q;
  side_t            side2_q;
  kind_e            kind2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (en) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ab2_q   <= ProdW'(a1_q) * ProdW'(b1_q);
      aa2_q   <= ProdW'(a1_q) * ProdW'(a1_q);
      bb2_q   <= ProdW'(b1_q) * ProdW'(b1_q);
      sum2_q  <= SumW'(a1_q) + SumW'(b1_q);
      side2_q <= '{neg: neg1_q, direct: direct_d, dmag: dmag_d};
      kind2_q <= kind1_q;
    end
  end

  // stage 3: partial products of ab*(a+b) and the denominator
  logic [DenW-1:0] den_d;

  always_comb begin
    case (kind2_q)
      KIND_VANLEER: den_d = DenW'(sum2_q);
      KIND_OSPRE:   den_d = (DenW'(aa2_q) + DenW'(ab2_q) + DenW'(bb2_q)) << 1;
      default:      den_d = DenW'(aa2_q) + DenW'(bb2_q);
    endcase
    if (side2_q.direct) begin
      den_d = DenW'(1);
    end
  end

  logic             v3_q;
  logic [SumW+31:0] pl3_q, ph3_q;
  logic [ProdW-1:0] ab3_q;
  logic [DenW-1:0]  den3_q;
  side_t            side3_q;
  kind_e            kind3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (en) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pl3_q   <= (SumW+32)'(ab2_q[31:0]) * (SumW+32)'(sum2_q);
      ph3_q   <= (SumW+32)'(ab2_q[63:32]) * (SumW+32)'(sum2_q);
      ab3_q   <= ab2_q;
      den3_q  <= den_d;
      side3_q <= side2_q;
      kind3_q <= kind2_q;
    end
  end

  // numerator into the divider
  logic [NumW:0]   tri_sum;
  logic [NumW-1:0] t_prod, num_d;

  always_comb begin
    tri_sum = ((NumW+1)'(ph3_q) << 32) + (NumW+1)'(pl3_q);
    t_prod  = tri_sum[NumW-1:0];
    case (kind3_q)
      KIND_VANLEER: num_d = NumW'(ab3_q) << 1;
      KIND_OSPRE:   num_d = (t_prod << 1) + t_prod;
      default:      num_d = t_prod;
    endcase
    if (side3_q.direct) begin
      num_d = '0;
    end
  end

  logic            dv_valid;
  logic [QuoW-1:0] dv_quo;
  logic [NumW-1:0] dv_rem;
  logic [DenW-1:0] dv_den;
  side_t           dv_side;

  slb_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v3_q),
    .num_i   (num_d),
    .den_i   (den3_q),
    .side_i  (side3_q),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem),
    .den_o   (dv_den),
    .side_o  (dv_side)
  );

  // rounding, sign and saturation
  logic [ResW-1:0]  mag_f;
  logic             rnd;
  logic [WordW-1:0] res_d;
  logic             sat_d;
  localparam logic [ResW-1:0] PosLim = ResW'({1'b0, {(WordW-1){1'b1}}});
  localparam logic [ResW-1:0] NegLim = ResW'({1'b1, {(WordW-1){1'b0}}});

  always_comb begin
    rnd   = ((NumW+1)'(dv_rem) << 1) >= (NumW+1)'(dv_den);
    mag_f = dv_side.direct ? dv_side.dmag : (ResW'(dv_quo) + ResW'(rnd));
    sat_d = 1'b0;
    if (dv_side.neg) begin
      if (mag_f > NegLim) begin
        sat_d = 1'b1;
        res_d = NegLim[WordW-1:0];
      end else begin
        res_d = WordW'(-mag_f);
      end
    end else begin
      if (mag_f > PosLim) begin
        sat_d = 1'b1;
        res_d = PosLim[WordW-1:0];
      end else begin
        res_d = mag_f[WordW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  logic [WordW-1:0] res_q;
  logic             sat_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign limited_slope_o = res_q;
  assign saturated_o     = sat_q;

endmodule

### rtl/slb_div.sv
// pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module slb_div (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic [slb_pkg::NumW-1:0] num_i,
  input  logic [slb_pkg::DenW-1:0] den_i,
  input  slb_pkg::side_t         side_i,
  output logic                   valid_o,
  output logic [slb_pkg::QuoW-1:0] quo_o,
  output logic [slb_pkg::NumW-1:0] rem_o,
  output logic [slb_pkg::DenW-1:0] den_o,
  output slb_pkg::side_t         side_o
);
  import slb_pkg::*;

  localparam int unsigned CmpW = NumW + 3;

  logic [NumW-1:0] rem_q  [0:QuoW];
  logic [QuoW-1:0] quo_q  [0:QuoW];
  logic [DenW-1:0] den_q  [0:QuoW];
  side_t           side_q [0:QuoW];
  logic            vld_q  [0:QuoW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 1; i <= QuoW; i++) begin : g_stage
    logic [CmpW-1:0] rem_ext;
    logic [CmpW-1:0] den_sh;
    logic [CmpW-1:0] diff;
    logic            ge;

    assign rem_ext = CmpW'(rem_q[i-1]);
    assign den_sh  = CmpW'(den_q[i-1]) << (QuoW - i);
    assign diff    = rem_ext - den_sh;
    assign ge      = rem_ext >= den_sh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vld_q[i-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= ge ? diff[NumW-1:0] : rem_q[i-1];
        quo_q[i]  <= {quo_q[i-1][QuoW-2:0], ge};
        den_q[i]  <= den_q[i-1];
        side_q[i] <= side_q[i-1];
      end
    end
  end

  assign valid_o = vld_q[QuoW];
  assign quo_o   = quo_q[QuoW];
  assign rem_o   = rem_q[QuoW];
  assign den_o   = den_q[QuoW];
  assign side_o  = side_q[QuoW];

endmodule
